// ----- rtl/core/vrq_pkg.sv -----
`default_nettype none

package vrq_pkg;

  // Field widths of the item ports.
  localparam int unsigned VRUN_W      = 63;
  localparam int unsigned TASK_W      = 8;
  localparam int unsigned PRIO_W      = 2;
  localparam int unsigned SLICE_W     = 10;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned BUDGET_W    = 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_VRUN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PRIO    = 2'd2;

  // Reset values and defaults.
  localparam logic [BUDGET_W-1:0] SLICE_RESET       = 8'd40;
  localparam int unsigned         QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned         TASK_ID_BITS_DEF  = 8;

  // Divider: quotient bits resolved per cycle.
  localparam int unsigned DIV_STEP_BITS = 2;

  // Action codes.
  localparam logic ACT_ENQUEUE  = 1'b0;
  localparam logic ACT_SCHEDULE = 1'b1;

  // Status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Operation issued to every cell of the queue in the same cycle.
  typedef struct packed {
    logic ins;
    logic pop;
  } vrq_cmd_t;

  typedef struct packed {
    logic              action;
    logic [TASK_W-1:0] task_id;
    logic [VRUN_W-1:0] vtime;
    logic [PRIO_W-1:0] priority_req;
    logic              running;
    logic [SLICE_W-1:0] slice_now;
  } vrq_in_t;

  typedef struct packed {
    logic [TASK_W-1:0]  next_task;
    logic               switched;
    logic [SLICE_W-1:0] slice_next;
    logic [COUNT_W-1:0] task_count;
    logic               status;
  } vrq_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/vrq_cell.sv -----
`default_nettype none

module vrq_cell
  import vrq_pkg::*;
#(
  parameter int unsigned TASK_ID_BITS = TASK_ID_BITS_DEF,
  parameter int unsigned FILL_W       = 5,
  parameter int unsigned INDEX        = 0
) (
  input  wire logic                    clk_i,
  input  wire vrq_cmd_t                cmd_i,
  input  wire logic [FILL_W-1:0]       fill_i,
  input  wire logic [VRUN_W-1:0]       key_vrun_i,
  input  wire logic [TASK_ID_BITS-1:0] key_task_i,
  input  wire logic [PRIO_W-1:0]       key_prio_i,
  input  wire logic                    left_mark_i,
  input  wire logic [VRUN_W-1:0]       left_vrun_i,
  input  wire logic [TASK_ID_BITS-1:0] left_task_i,
  input  wire logic [PRIO_W-1:0]       left_prio_i,
  input  wire logic [VRUN_W-1:0]       right_vrun_i,
  input  wire logic [TASK_ID_BITS-1:0] right_task_i,
  input  wire logic [PRIO_W-1:0]       right_prio_i,
  output      logic                    mark_o,
  output      logic [VRUN_W-1:0]       vrun_o,
  output      logic [TASK_ID_BITS-1:0] task_o,
  output      logic [PRIO_W-1:0]       prio_o
);

  logic [VRUN_W-1:0]       vrun_q;
  logic [TASK_ID_BITS-1:0] task_q;
  logic [PRIO_W-1:0]       prio_q;
  logic                    occupied;
  logic                    take_new;
  logic                    take_left;

  // A cell is at or past the insert point when it is empty or its key is not smaller.
  // The queue is sorted, so the marks form one run from the insert point to the end.
  assign occupied  = FILL_W'(INDEX) < fill_i;
  assign mark_o    = !occupied || (vrun_q >= key_vrun_i);
  assign take_new  = cmd_i.ins && mark_o && !left_mark_i;
  assign take_left = cmd_i.ins && mark_o && left_mark_i;

  // Entry storage: load the new key, shift right on insert, shift left on pop.
  always_ff @(posedge clk_i) begin
    if (take_new) begin
      vrun_q <= key_vrun_i;
      task_q <= key_task_i;
      prio_q <= key_prio_i;
    end else if (take_left) begin
      vrun_q <= left_vrun_i;
      task_q <= left_task_i;
      prio_q <= left_prio_i;
    end else if (cmd_i.pop) begin
      vrun_q <= right_vrun_i;
      task_q <= right_task_i;
      prio_q <= right_prio_i;
    end
  end

  assign vrun_o = vrun_q;
  assign task_o = task_q;
  assign prio_o = prio_q;

endmodule

`default_nettype wire

// ----- rtl/core/vrq_div.sv -----
`default_nettype none

module vrq_div
  import vrq_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [BUDGET_W-1:0] dividend_i,
  input  wire logic [COUNT_W-1:0]  divisor_i,
  output      logic                done_o,
  output      logic [BUDGET_W-1:0] quotient_o
);

  localparam int unsigned DIV_CYCLES = BUDGET_W / DIV_STEP_BITS;
  localparam int unsigned CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [COUNT_W-1:0]  divisor_q;
  logic [COUNT_W-1:0]  rem_q;
  logic [COUNT_W-1:0]  rem_d;
  logic [BUDGET_W-1:0] quo_q;
  logic [BUDGET_W-1:0] quo_d;
  logic [COUNT_W:0]    trial;

  // Restoring division, a few quotient bits per cycle. The dividend bits are
  // shifted out of the top of quo_q while quotient bits enter at the bottom.
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int s = 0; s < int'(DIV_STEP_BITS); s++) begin
      trial = {rem_d, quo_d[BUDGET_W-1]};
      if (trial >= {1'b0, divisor_q}) begin
        rem_d = COUNT_W'(trial - {1'b0, divisor_q});
        quo_d = {quo_d[BUDGET_W-2:0], 1'b1};
      end else begin
        rem_d = COUNT_W'(trial);
        quo_d = {quo_d[BUDGET_W-2:0], 1'b0};
      end
    end
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/core/vruntime_ready_queue_scheduler.sv -----
// Flow: an enqueue item passes the insert and result states into the output register; a
// schedule item passes the pop state first, and the divider state too on a reload.
// Throughput: one item at a time; the next is taken after the result is loaded, which
// waits while the output register holds an untaken result. The cell chain does the pop
// and the sorted insert; reloads use the iterative divider (2 quotient bits per cycle).
// Reset: queue empty, running count 1, slice budget 40, idle runtime and priority 0.
`default_nettype none

module vruntime_ready_queue_scheduler
  import vrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire vrq_in_t               in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      vrq_out_t              out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]              state_q;
  logic [FILL_W-1:0]       fill_q;
  logic [COUNT_W-1:0]      cnt_q;

  logic [BUDGET_W-1:0]     budget_q;
  logic [VRUN_W-1:0]       idle_vrun_q;
  logic [PRIO_W-1:0]       idle_prio_q;

  // Latched item.
  logic                    act_q;
  logic [TASK_ID_BITS-1:0] id_q;
  logic [VRUN_W-1:0]       vr_q;
  logic [PRIO_W-1:0]       prio_q;
  logic                    run_q;
  logic [SLICE_W-1:0]      slice_q;

  // Decision and pending insert.
  logic [TASK_ID_BITS-1:0] next_q;
  logic                    sw_q;
  logic [PRIO_W-1:0]       t_prio_q;
  logic                    status_q;
  logic                    ins_en_q;
  logic [VRUN_W-1:0]       ins_vrun_q;
  logic [TASK_ID_BITS-1:0] ins_task_q;
  logic [PRIO_W-1:0]       ins_prio_q;

  logic                    out_valid_q;
  vrq_out_t                out_q;

  // Cell chain.
  vrq_cmd_t                cmd;
  logic                    cell_mark [QUEUE_DEPTH];
  logic [VRUN_W-1:0]       cell_vrun [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] cell_task [QUEUE_DEPTH];
  logic [PRIO_W-1:0]       cell_prio [QUEUE_DEPTH];

  logic                    in_xfer;
  logic                    full;
  logic                    empty;
  logic                    do_ins;
  logic [VRUN_W-1:0]       head_vrun;
  logic [TASK_ID_BITS-1:0] head_task;
  logic [PRIO_W-1:0]       head_prio;
  logic                    take_sw;
  logic                    out_load;
  logic                    div_start;
  logic                    div_done;
  logic [BUDGET_W-1:0]     div_quo;
  logic [COUNT_W-1:0]      cnt_after;
  logic [COUNT_W-1:0]      divisor;
  logic [SLICE_W-1:0]      quo_ext;
  logic [SLICE_W-1:0]      reload;
  vrq_out_t                res;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign full   = fill_q >= FILL_W'(QUEUE_DEPTH);
  assign empty  = (fill_q == '0);
  assign do_ins = (state_q == ST_INS) && ins_en_q && !full;

  // Head of the queue, or the idle task when the queue is empty.
  assign head_vrun = empty ? idle_vrun_q : cell_vrun[0];
  assign head_task = empty ? '0 : cell_task[0];
  assign head_prio = empty ? idle_prio_q : cell_prio[0];
  assign take_sw   = (vr_q >= head_vrun) || !run_q;

  assign cmd.pop = (state_q == ST_POP) && !empty;
  assign cmd.ins = do_ins;

  // One cell per queue entry, linked to its neighbors; the first cell's left input is the insert key.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                    left_mark;
    logic [VRUN_W-1:0]       left_vrun;
    logic [TASK_ID_BITS-1:0] left_task;
    logic [PRIO_W-1:0]       left_prio;
    logic [VRUN_W-1:0]       right_vrun;
    logic [TASK_ID_BITS-1:0] right_task;
    logic [PRIO_W-1:0]       right_prio;

    if (i == 0) begin : g_first
      assign left_mark = 1'b0;
      assign left_vrun = ins_vrun_q;
      assign left_task = ins_task_q;
      assign left_prio = ins_prio_q;
    end else begin : g_inner_left
      assign left_mark = cell_mark[i-1];
      assign left_vrun = cell_vrun[i-1];
      assign left_task = cell_task[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_vrun = cell_vrun[i];
      assign right_task = cell_task[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner_right
      assign right_vrun = cell_vrun[i+1];
      assign right_task = cell_task[i+1];
      assign right_prio = cell_prio[i+1];
    end

    vrq_cell #(
      .TASK_ID_BITS (TASK_ID_BITS),
      .FILL_W       (FILL_W),
      .INDEX        (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .fill_i       (fill_q),
      .key_vrun_i   (ins_vrun_q),
      .key_task_i   (ins_task_q),
      .key_prio_i   (ins_prio_q),
      .left_mark_i  (left_mark),
      .left_vrun_i  (left_vrun),
      .left_task_i  (left_task),
      .left_prio_i  (left_prio),
      .right_vrun_i (right_vrun),
      .right_task_i (right_task),
      .right_prio_i (right_prio),
      .mark_o       (cell_mark[i]),
      .vrun_o       (cell_vrun[i]),
      .task_o       (cell_task[i]),
      .prio_o       (cell_prio[i])
    );
  end

  // Slice reload: budget divided by the running count after any requeue,
  // a zero count taken as one. The requeue lands in the same cycle as the start.
  assign div_start = (state_q == ST_INS) && (act_q == ACT_SCHEDULE) && (slice_q == '0);
  assign cnt_after = do_ins ? cnt_q + 1'b1 : cnt_q;
  assign divisor   = (cnt_after == '0) ? COUNT_W'(1) : cnt_after;

  vrq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (budget_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign quo_ext = SLICE_W'(div_quo);
  assign reload  = t_prio_q[1] ? SLICE_W'(quo_ext + (quo_ext << 1)) : quo_ext;

  // Result assembly.
  always_comb begin
    res            = '0;
    res.next_task  = TASK_W'(next_q);
    res.switched   = sw_q;
    res.slice_next = ((act_q == ACT_SCHEDULE) && (slice_q == '0)) ? reload : slice_q;
    res.task_count = cnt_q;
    res.status     = status_q;
  end

  assign out_load = (state_q == ST_RES) && (!out_valid_q || out_ready_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= SLICE_RESET;
      idle_vrun_q <= '0;
      idle_prio_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SLICE_BUDGET: budget_q    <= cfg_data_i[BUDGET_W-1:0];
        CFG_IDLE_VRUN:    idle_vrun_q <= cfg_data_i[VRUN_W-1:0];
        CFG_IDLE_PRIO:    idle_prio_q <= cfg_data_i[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, queue fill and running count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= COUNT_W'(1);
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= (in_data_i.action == ACT_SCHEDULE) ? ST_POP : ST_INS;
          end
        end
        ST_POP: begin
          if (!empty) begin
            fill_q <= fill_q - 1'b1;
            cnt_q  <= cnt_q - 1'b1;
          end
          state_q <= ST_INS;
        end
        ST_INS: begin
          if (do_ins) begin
            fill_q <= fill_q + 1'b1;
            cnt_q  <= cnt_q + 1'b1;
          end
          state_q <= div_start ? ST_DIV : ST_RES;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_RES;
          end
        end
        ST_RES: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item, decision and insert operands.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q      <= in_data_i.action;
      id_q       <= TASK_ID_BITS'(in_data_i.task_id);
      vr_q       <= in_data_i.vtime;
      prio_q     <= in_data_i.priority_req;
      run_q      <= in_data_i.running;
      slice_q    <= in_data_i.slice_now;
      next_q     <= '0;
      sw_q       <= 1'b0;
      ins_en_q   <= (TASK_ID_BITS'(in_data_i.task_id) != '0);
      ins_vrun_q <= in_data_i.vtime;
      ins_task_q <= TASK_ID_BITS'(in_data_i.task_id);
      ins_prio_q <= in_data_i.priority_req;
    end
    if (state_q == ST_POP) begin
      t_prio_q <= head_prio;
      sw_q     <= take_sw;
      if (take_sw) begin
        // Switch: requeue the current task if it still runs.
        next_q     <= head_task;
        ins_en_q   <= run_q && (id_q != '0);
        ins_vrun_q <= vr_q;
        ins_task_q <= id_q;
        ins_prio_q <= prio_q;
      end else begin
        // Keep the current task and put the popped one back.
        next_q     <= id_q;
        ins_en_q   <= (head_task != '0);
        ins_vrun_q <= head_vrun;
        ins_task_q <= head_task;
        ins_prio_q <= head_prio;
      end
    end
    if (state_q == ST_INS) begin
      status_q <= (ins_en_q && full) ? STATUS_FULL : STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The queue never holds more entries than cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  // The two front entries stay in ascending runtime order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= FILL_W'(2)) |-> (cell_vrun[0] <= cell_vrun[1]))
    else $error("queue head out of order");

  // A pop from a non-empty queue removes exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP && !empty) |=> (fill_q == $past(fill_q) - 1'b1))
    else $error("pop did not remove one entry");

  // The divider runs only for a schedule item whose slice has run out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (act_q == ACT_SCHEDULE && slice_q == '0))
    else $error("slice reload without expired slice");

  // A new result appears only after the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RES))
    else $error("result loaded outside the result state");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import vrq_pkg::*;

  localparam int unsigned QDEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 126;
  localparam logic [VRUN_W-1:0] VRUN_MAX = '1;
  // Index past the last register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    vrq_in_t  item;
    bit       typed;
    vrq_out_t result;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  vrq_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  vrq_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the ready queue and the scheduler registers.
  logic [VRUN_W-1:0]  rq_vrun [QDEPTH];
  logic [TASK_W-1:0]  rq_task [QDEPTH];
  logic [PRIO_W-1:0]  rq_prio [QDEPTH];
  int unsigned        rq_fill;
  logic [COUNT_W-1:0] runnable;
  logic [BUDGET_W-1:0] budget;
  logic [VRUN_W-1:0]  idle_vrun;
  logic [PRIO_W-1:0]  idle_prio;

  vrq_out_t    outcome_q [$];
  stim_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          in_idle = 1'b1;
  bit          out_idle = 1'b1;

  vruntime_ready_queue_scheduler DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  // Sorted insert ahead of the first entry with an equal or larger runtime.
  // Returns 0 when the queue is full and the task is dropped.
  function automatic bit ready_insert(logic [TASK_W-1:0] id, logic [VRUN_W-1:0] vr,
                                      logic [PRIO_W-1:0] pr);
    int unsigned pos;
    int unsigned k;
    if (id == '0) return 1'b1;
    if (rq_fill >= QDEPTH) return 1'b0;
    pos = 0;
    while (pos < rq_fill && rq_vrun[pos] < vr) pos++;
    for (k = rq_fill; k > pos; k--) begin
      rq_vrun[k] = rq_vrun[k-1];
      rq_task[k] = rq_task[k-1];
      rq_prio[k] = rq_prio[k-1];
    end
    rq_vrun[pos] = vr;
    rq_task[pos] = id;
    rq_prio[pos] = pr;
    rq_fill++;
    runnable = runnable + 1'b1;
    return 1'b1;
  endfunction

  // Works out the result of one item and advances the shadow queue.
  function automatic vrq_out_t schedule_outcome(vrq_in_t it);
    vrq_out_t          o;
    logic [TASK_W-1:0] t_id;
    logic [VRUN_W-1:0] t_vr;
    logic [PRIO_W-1:0] t_pr;
    int unsigned       slc;
    int unsigned       div;
    int unsigned       k;
    bit                ok;
    o = '0;
    slc = 32'(it.slice_now);
    if (it.action == ACT_ENQUEUE) begin
      ok = ready_insert(it.task_id, it.vtime, it.priority_req);
      o.status = ok ? STATUS_OK : STATUS_FULL;
    end else begin
      // Pop the head, or fall back to the idle task on an empty queue.
      if (rq_fill == 0) begin
        t_id = '0;
        t_vr = idle_vrun;
        t_pr = idle_prio;
      end else begin
        t_id = rq_task[0];
        t_vr = rq_vrun[0];
        t_pr = rq_prio[0];
        for (k = 1; k < rq_fill; k++) begin
          rq_vrun[k-1] = rq_vrun[k];
          rq_task[k-1] = rq_task[k];
          rq_prio[k-1] = rq_prio[k];
        end
        rq_fill--;
        runnable = runnable - 1'b1;
      end
      if (it.vtime >= t_vr || !it.running) begin
        if (it.running) ok = ready_insert(it.task_id, it.vtime, it.priority_req);
        o.next_task = t_id;
        o.switched  = 1'b1;
      end else begin
        ok = ready_insert(t_id, t_vr, t_pr);
        o.next_task = it.task_id;
      end
      // Slice reload uses the popped task's priority and the final count.
      if (it.slice_now == '0) begin
        div = (runnable == '0) ? 1 : 32'(runnable);
        slc = budget / div;
        if (t_pr >= 2) slc = slc * 3;
      end
      o.status = STATUS_OK;
    end
    o.slice_next = slc[SLICE_W-1:0];
    o.task_count = runnable;
    return o;
  endfunction

  function automatic vrq_in_t mk_item(logic act, logic [TASK_W-1:0] id,
                                      logic [VRUN_W-1:0] vr, logic [PRIO_W-1:0] pr,
                                      logic run, logic [SLICE_W-1:0] slc);
    vrq_in_t it;
    it.action       = act;
    it.task_id      = id;
    it.vtime        = vr;
    it.priority_req = pr;
    it.running      = run;
    it.slice_now    = slc;
    return it;
  endfunction

  function automatic vrq_out_t mk_result(logic [TASK_W-1:0] nt, logic sw,
                                         logic [SLICE_W-1:0] slc, logic [COUNT_W-1:0] cnt,
                                         logic st);
    vrq_out_t o;
    o.next_task  = nt;
    o.switched   = sw;
    o.slice_next = slc;
    o.task_count = cnt;
    o.status     = st;
    return o;
  endfunction

  function automatic void add_row(vrq_in_t it, bit typed, vrq_out_t res);
    stim_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.result = res;
    plan.push_back(row);
  endfunction

  // Mostly small runtimes so that equal keys and both comparison outcomes are common.
  function automatic vrq_in_t random_item(int unsigned enq_pct);
    logic [63:0]       wide;
    logic [VRUN_W-1:0] vr;
    logic [TASK_W-1:0] id;
    logic [SLICE_W-1:0] slc;
    case ($urandom_range(0, 9))
      0: vr = VRUN_MAX;
      1: begin
        wide = {$urandom, $urandom};
        vr = wide[VRUN_W-1:0];
      end
      2: vr = '0;
      default: vr = VRUN_W'($urandom_range(0, 40));
    endcase
    id = ($urandom_range(0, 9) == 0) ? '0 : TASK_W'($urandom_range(1, 255));
    slc = ($urandom_range(0, 2) == 0) ? '0 : SLICE_W'($urandom_range(0, 1023));
    return mk_item(($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_SCHEDULE, id, vr,
                   PRIO_W'($urandom_range(0, 3)), $urandom_range(0, 3) != 0, slc);
  endfunction

  // Sends one item, after a random gap while in_idle is set; called and returns at a falling edge.
  task automatic send_item(vrq_in_t it, bit typed, vrq_out_t typed_res);
    int unsigned gap;
    vrq_out_t    pred;
    gap = in_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = schedule_outcome(it);
    outcome_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // One register write transfer; the shadow registers follow on acceptance.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SLICE_BUDGET: budget = data[BUDGET_W-1:0];
      CFG_IDLE_VRUN:    idle_vrun = data[VRUN_W-1:0];
      CFG_IDLE_PRIO:    idle_prio = data[PRIO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Holds the sender until every outcome has been seen, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[vruntime_ready_queue_scheduler] ERROR");
    $finish;
  end

  // Compare each result transfer with the oldest outcome still pending.
  always @(posedge clk) begin
    vrq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $error("result with no outcome pending: next_task %0d", out_data.next_task);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("next_task", want.next_task, out_data.next_task);
        check_field("switched", want.switched, out_data.switched);
        check_field("slice_next", want.slice_next, out_data.slice_next);
        check_field("task_count", want.task_count, out_data.task_count);
        check_field("status", want.status, out_data.status);
      end
    end
  end

  // Result side: random stall before each transfer, none while out_idle is clear.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned i;
    int unsigned k;
    int unsigned ph;
    int unsigned enq_pct;
    logic [63:0] wide;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rq_fill   = 0;
    runnable  = COUNT_W'(1);
    budget    = SLICE_RESET;
    idle_vrun = '0;
    idle_prio = '0;
    for (k = 0; k < QDEPTH; k++) begin
      rq_vrun[k] = '0;
      rq_task[k] = '0;
      rq_prio[k] = '0;
    end

    // Directed part: empty-queue schedule, idle enqueue, extremes, equal keys,
    // switch without requeue, keeping the current task, and a full queue.
    add_row(mk_item(ACT_SCHEDULE, 8'd5, '0, 2'd0, 1'b1, 10'd7), 1'b1,
            mk_result(8'd0, 1'b1, 10'd7, 5'd2, STATUS_OK));
    add_row(mk_item(ACT_ENQUEUE, 8'd0, 63'd123, 2'd1, 1'b0, 10'd1023), 1'b1,
            mk_result(8'd0, 1'b0, 10'd1023, 5'd2, STATUS_OK));
    add_row(mk_item(ACT_ENQUEUE, 8'd255, VRUN_MAX, 2'd3, 1'b1, 10'd0), 1'b1,
            mk_result(8'd0, 1'b0, 10'd0, 5'd3, STATUS_OK));
    add_row(mk_item(ACT_ENQUEUE, 8'd1, '0, 2'd2, 1'b0, 10'd5), 1'b1,
            mk_result(8'd0, 1'b0, 10'd5, 5'd4, STATUS_OK));
    add_row(mk_item(ACT_SCHEDULE, 8'd9, VRUN_MAX, 2'd1, 1'b1, 10'd0), 1'b0, '0);
    add_row(mk_item(ACT_SCHEDULE, 8'd12, 63'd1, 2'd0, 1'b0, 10'd1023), 1'b0, '0);
    add_row(mk_item(ACT_SCHEDULE, 8'd20, '0, 2'd3, 1'b1, 10'd0), 1'b0, '0);
    for (k = 0; k < 14; k++)
      add_row(mk_item(ACT_ENQUEUE, TASK_W'(30 + k), VRUN_W'(((k * 7) % 5) * 1000),
                      PRIO_W'(k % 4), k[0], SLICE_W'(k * 73)), 1'b0, '0);
    add_row(mk_item(ACT_ENQUEUE, 8'd170, 63'd500, 2'd1, 1'b1, 10'd511), 1'b1,
            mk_result(8'd0, 1'b0, 10'd511, 5'd17, STATUS_FULL));
    add_row(mk_item(ACT_ENQUEUE, 8'd85, VRUN_MAX, 2'd2, 1'b0, 10'd0), 1'b1,
            mk_result(8'd0, 1'b0, 10'd0, 5'd17, STATUS_FULL));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < plan.size(); i++)
      send_item(plan[i].item, plan[i].typed, plan[i].result);

    // Random phases, each under its own register setting.
    for (ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(CFG_SLICE_BUDGET, CFG_DATA_W'(255));
          write_reg(CFG_IDLE_VRUN, VRUN_MAX);
          write_reg(CFG_IDLE_PRIO, CFG_DATA_W'(3));
          wide = {$urandom, $urandom};
          write_reg(CFG_SPARE, wide[CFG_DATA_W-1:0]);
          enq_pct = 70;
        end
        2: begin
          write_reg(CFG_SLICE_BUDGET, CFG_DATA_W'(1));
          write_reg(CFG_IDLE_VRUN, '0);
          write_reg(CFG_IDLE_PRIO, CFG_DATA_W'(2));
          enq_pct = 40;
        end
        3: begin
          write_reg(CFG_SLICE_BUDGET, CFG_DATA_W'($urandom_range(1, 255)));
          write_reg(CFG_IDLE_VRUN, CFG_DATA_W'($urandom_range(0, 40)));
          write_reg(CFG_IDLE_PRIO, CFG_DATA_W'($urandom_range(0, 3)));
          enq_pct = 60;
        end
        4: begin
          write_reg(CFG_SLICE_BUDGET, CFG_DATA_W'(SLICE_RESET));
          write_reg(CFG_IDLE_VRUN, CFG_DATA_W'(20));
          write_reg(CFG_IDLE_PRIO, CFG_DATA_W'(1));
          enq_pct = 50;
        end
        default: enq_pct = 55;
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Now and then switch idling on or off on either side.
        if ($urandom_range(0, 29) == 0) in_idle = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 29) == 0) out_idle = $urandom_range(0, 2) != 0;
        send_item(random_item(enq_pct), 1'b0, '0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[vruntime_ready_queue_scheduler] OK");
    end else begin
      $display("[vruntime_ready_queue_scheduler] ERROR");
    end
    $finish;
  end

endmodule
